[rtl/cmf_pkg.sv]
// shared types and constants of the cigar local match filter
// no dependencies; imported by every module of the block
`default_nettype none

package cmf_pkg;

	localparam int CFG_BITS = 16;
	localparam int IDX_BITS = 2;
	localparam int CHAR_BITS = 8;
	localparam int STATUS_BITS = 2;

	localparam logic [IDX_BITS-1:0] CFG_MIN_ALIGNED = 2'd0;
	localparam logic [IDX_BITS-1:0] CFG_MAX_CLIP = 2'd1;
	localparam logic [IDX_BITS-1:0] CFG_KEEP_INTERNAL = 2'd2;

	localparam logic [CFG_BITS-1:0] MIN_ALIGNED_RESET = 16'd0;
	localparam logic [CFG_BITS-1:0] MAX_CLIP_RESET = 16'hFFFF;

	localparam logic [CHAR_BITS-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_M = 8'h4D;
	localparam logic [CHAR_BITS-1:0] CH_I = 8'h49;
	localparam logic [CHAR_BITS-1:0] CH_D = 8'h44;
	localparam logic [CHAR_BITS-1:0] CH_S = 8'h53;

	localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_ALL_CLIP = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic seen_core;
		logic overflow;
	} cmf_flags_t;

endpackage

`default_nettype wire

[rtl/cmf_if.sv]
// valid/ready channel interfaces for cigar characters and filter results
// uses no package
`default_nettype none

interface cmf_in_if #(parameter int POS_BITS = 31);
	logic                valid;
	logic                ready;
	logic [7:0]          cigar_char;
	logic [POS_BITS-1:0] read_start;
	logic [POS_BITS-1:0] reference_length;
	logic                last_char;

	modport source (output valid, cigar_char, read_start, reference_length, last_char,
		input ready);
	modport sink (input valid, cigar_char, read_start, reference_length, last_char,
		output ready);
endinterface

interface cmf_out_if #(parameter int LEN_BITS = 16, parameter int POS_BITS = 31);
	logic                valid;
	logic                ready;
	logic                accepted;
	logic [1:0]          status;
	logic                is_local;
	logic [POS_BITS-1:0] new_start;
	logic [POS_BITS-1:0] new_end;
	logic [LEN_BITS:0]   extra_mismatches;
	logic [LEN_BITS-1:0] aligned_size;

	modport source (output valid, accepted, status, is_local, new_start, new_end,
		extra_mismatches, aligned_size, input ready);
	modport sink (input valid, accepted, status, is_local, new_start, new_end,
		extra_mismatches, aligned_size, output ready);
endinterface

`default_nettype wire

[rtl/cmf_front.sv]
// front end: takes cigar characters, keeps the running run/length/clip counters
// and hands a finished string summary to the queue; uses cmf_pkg and cmf_in_if
`default_nettype none

module cmf_front
	import cmf_pkg::*;
#(
	parameter int LEN_BITS = 16,
	parameter int POS_BITS = 31
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	cmf_in_if.sink                   in_word,
	input  wire logic                q_full,
	output logic                     push,
	output logic [LEN_BITS-1:0]      aligned,
	output logic [LEN_BITS-1:0]      total,
	output logic [LEN_BITS-1:0]      left_clip,
	output logic [LEN_BITS-1:0]      trail_clip,
	output cmf_flags_t               flags,
	output logic [POS_BITS-1:0]      start,
	output logic [POS_BITS-1:0]      ref_len
);

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	logic [LEN_BITS-1:0] run_q, aligned_q, total_q, left_q, trail_q;
	logic                seen_q, ovf_q;
	logic [LEN_BITS-1:0] run_n, aligned_n, total_n, left_n, trail_n;
	logic                seen_n, ovf_n;
	logic                accept, is_digit, is_mid;
	logic [3:0]          digit;
	logic [LEN_BITS+3:0] prod;
	logic [LEN_BITS:0]   tot_sum, al_sum, left_sum, trail_sum;

	assign in_word.ready = !q_full;
	assign accept = in_word.valid && in_word.ready;
	assign push = accept && in_word.last_char;

	assign is_digit = in_word.cigar_char <= CH_NINE;
	assign is_mid = (in_word.cigar_char == CH_M) || (in_word.cigar_char == CH_I) ||
		(in_word.cigar_char == CH_D);
	assign digit = (in_word.cigar_char >= CH_ZERO) ? 4'(in_word.cigar_char - CH_ZERO) : 4'd0;
	assign prod = ({4'd0, run_q} << 3) + ({4'd0, run_q} << 1) + (LEN_BITS+4)'(digit);

	assign tot_sum = {1'b0, total_q} + {1'b0, run_q};
	assign al_sum = {1'b0, aligned_q} + {1'b0, run_q};
	assign left_sum = {1'b0, left_q} + {1'b0, run_q};
	assign trail_sum = {1'b0, trail_q} + {1'b0, run_q};

	always_comb begin
		run_n = run_q;
		aligned_n = aligned_q;
		total_n = total_q;
		left_n = left_q;
		trail_n = trail_q;
		seen_n = seen_q;
		ovf_n = ovf_q;
		if (is_digit) begin
			if (prod[LEN_BITS+3:LEN_BITS] != 4'd0) begin
				run_n = LEN_MAX;
				ovf_n = 1'b1;
			end else begin
				run_n = prod[LEN_BITS-1:0];
			end
		end else begin
			run_n = '0;
			total_n = tot_sum[LEN_BITS] ? LEN_MAX : tot_sum[LEN_BITS-1:0];
			if (tot_sum[LEN_BITS]) begin
				ovf_n = 1'b1;
			end
			if (in_word.cigar_char == CH_S) begin
				if (seen_q) begin
					trail_n = trail_sum[LEN_BITS] ? LEN_MAX : trail_sum[LEN_BITS-1:0];
					if (trail_sum[LEN_BITS]) begin
						ovf_n = 1'b1;
					end
				end else begin
					left_n = left_sum[LEN_BITS] ? LEN_MAX : left_sum[LEN_BITS-1:0];
					if (left_sum[LEN_BITS]) begin
						ovf_n = 1'b1;
					end
				end
			end else if (run_q != '0) begin
				seen_n = 1'b1;
				trail_n = '0;
				if (is_mid) begin
					aligned_n = al_sum[LEN_BITS] ? LEN_MAX : al_sum[LEN_BITS-1:0];
					if (al_sum[LEN_BITS]) begin
						ovf_n = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			aligned_q <= '0;
			total_q <= '0;
			left_q <= '0;
			trail_q <= '0;
			seen_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (in_word.last_char) begin
				run_q <= '0;
				aligned_q <= '0;
				total_q <= '0;
				left_q <= '0;
				trail_q <= '0;
				seen_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				run_q <= run_n;
				aligned_q <= aligned_n;
				total_q <= total_n;
				left_q <= left_n;
				trail_q <= trail_n;
				seen_q <= seen_n;
				ovf_q <= ovf_n;
			end
		end
	end

	assign aligned = aligned_n;
	assign total = total_n;
	assign left_clip = left_n;
	assign trail_clip = trail_n;
	assign flags = '{seen_core: seen_n, overflow: ovf_n};
	assign start = in_word.read_start;
	assign ref_len = in_word.reference_length;

endmodule

`default_nettype wire

[rtl/cmf_queue.sv]
// two-entry queue between the counting front end and the result back end
// generic data word; uses cmf_pkg only for the house import
`default_nettype none

module cmf_queue
	import cmf_pkg::*;
#(
	parameter int WIDTH = 96
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push, do_pop;

	assign full = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/cmf_back.sv]
// back end: two-stage result pipeline computing clamped bounds, extra
// mismatches and acceptance; uses cmf_pkg and cmf_out_if
`default_nettype none

module cmf_back
	import cmf_pkg::*;
#(
	parameter int LEN_BITS = 16,
	parameter int POS_BITS = 31
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_pop,
	input  wire logic [LEN_BITS-1:0] aligned,
	input  wire logic [LEN_BITS-1:0] total,
	input  wire logic [LEN_BITS-1:0] left_clip,
	input  wire logic [LEN_BITS-1:0] trail_clip,
	input  cmf_flags_t               flags,
	input  wire logic [POS_BITS-1:0] start,
	input  wire logic [POS_BITS-1:0] ref_len,
	input  wire logic [CFG_BITS-1:0] min_aligned,
	input  wire logic [CFG_BITS-1:0] max_clip,
	input  wire logic                keep_internal,
	cmf_out_if.source                out_word
);

	localparam int W = ((POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS) + 3;
	localparam int CW = ((LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS) + 1;
	localparam logic signed [W-1:0] POS_MAX_X = W'((64'd1 << POS_BITS) - 64'd1);

	logic adv1, adv2;

	// stage 1
	logic signed [W-1:0] start_x, rl_x, al_x, lc_x, rc_x;
	logic signed [W-1:0] re_c, left_ext_c, rl_m_re_c;
	logic                s2_low;
	logic [POS_BITS-1:0] s2_c;

	logic                vld_s1, local_s1, seen_s1, ovf_s1, int_l_s1, len_ok_s1, clip_ok_s1;
	logic [POS_BITS-1:0] start_s1, ref_len_s1, s2_s1;
	logic [LEN_BITS-1:0] rc_s1, al_s1;
	logic signed [W-1:0] re_s1, left_ext_s1, rl_m_re_s1;

	// stage 2
	logic signed [W-1:0] rc2_x, rl2_x, right_ext, e2, xsum;
	logic                take_rl, int_r, acc_c;
	logic [1:0]          status_c;
	logic [POS_BITS-1:0] ns_c, ne_c;
	logic [LEN_BITS:0]   extra_c;

	logic                vld_s2, acc_s2, local_s2;
	logic [1:0]          status_s2;
	logic [POS_BITS-1:0] ns_s2, ne_s2;
	logic [LEN_BITS:0]   extra_s2;
	logic [LEN_BITS-1:0] al_s2;

	assign adv2 = !vld_s2 || out_word.ready;
	assign adv1 = !vld_s1 || adv2;
	assign q_pop = adv1 && q_valid;

	assign start_x = $signed({{(W-POS_BITS){1'b0}}, start});
	assign rl_x = $signed({{(W-POS_BITS){1'b0}}, ref_len});
	assign al_x = $signed({{(W-LEN_BITS){1'b0}}, aligned});
	assign lc_x = $signed({{(W-LEN_BITS){1'b0}}, left_clip});
	assign rc_x = $signed({{(W-LEN_BITS){1'b0}}, trail_clip});

	assign re_c = start_x + al_x - W'(1);
	assign s2_low = start_x <= lc_x;
	assign s2_c = s2_low ? POS_BITS'(1) : POS_BITS'(start_x - lc_x);
	assign left_ext_c = s2_low ? start_x - W'(1) : lc_x;
	assign rl_m_re_c = rl_x + W'(1) - start_x - al_x;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			local_s1 <= aligned < total;
			seen_s1 <= flags.seen_core;
			ovf_s1 <= flags.overflow;
			int_l_s1 <= (left_clip != '0) && (start_x > W'(1)) && (start_x <= rl_x + W'(1));
			len_ok_s1 <= CW'(aligned) >= CW'(min_aligned);
			clip_ok_s1 <= (CW'(left_clip) + CW'(trail_clip)) <= CW'(max_clip);
			start_s1 <= start;
			ref_len_s1 <= ref_len;
			s2_s1 <= s2_c;
			rc_s1 <= trail_clip;
			al_s1 <= aligned;
			re_s1 <= re_c;
			left_ext_s1 <= left_ext_c;
			rl_m_re_s1 <= rl_m_re_c;
		end
	end

	assign rc2_x = $signed({{(W-LEN_BITS){1'b0}}, rc_s1});
	assign rl2_x = $signed({{(W-POS_BITS){1'b0}}, ref_len_s1});
	assign take_rl = rc2_x > rl_m_re_s1;
	assign right_ext = take_rl ? rl_m_re_s1 : rc2_x;
	assign e2 = take_rl ? rl2_x : re_s1 + rc2_x;
	assign xsum = left_ext_s1 + right_ext;
	assign int_r = (rc_s1 != '0) && !re_s1[W-1] && (rl_m_re_s1 > W'(0));

	always_comb begin
		status_c = ovf_s1 ? STATUS_OVERFLOW : STATUS_OK;
		extra_c = '0;
		if (!local_s1) begin
			acc_c = 1'b1;
			ns_c = start_s1;
			if (re_s1[W-1]) begin
				ne_c = '0;
			end else if (re_s1 > POS_MAX_X) begin
				ne_c = '1;
			end else begin
				ne_c = re_s1[POS_BITS-1:0];
			end
		end else if (!seen_s1) begin
			status_c = STATUS_ALL_CLIP;
			acc_c = 1'b0;
			ns_c = (start_s1 == '0) ? POS_BITS'(1) : start_s1;
			ne_c = (start_s1 == '0) ? '0 : start_s1 - POS_BITS'(1);
		end else begin
			acc_c = len_ok_s1 && clip_ok_s1 && (!(int_l_s1 || int_r) || keep_internal);
			ns_c = s2_s1;
			ne_c = e2[W-1] ? '0 : e2[POS_BITS-1:0];
			extra_c = xsum[W-1] ? '0 : xsum[LEN_BITS:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			acc_s2 <= acc_c;
			status_s2 <= status_c;
			local_s2 <= local_s1;
			ns_s2 <= ns_c;
			ne_s2 <= ne_c;
			extra_s2 <= extra_c;
			al_s2 <= al_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= q_valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	assign out_word.valid = vld_s2;
	assign out_word.accepted = acc_s2;
	assign out_word.status = status_s2;
	assign out_word.is_local = local_s2;
	assign out_word.new_start = ns_s2;
	assign out_word.new_end = ne_s2;
	assign out_word.extra_mismatches = extra_s2;
	assign out_word.aligned_size = al_s2;

endmodule

`default_nettype wire

[rtl/cigar_local_match_filter_top.sv]
// top level of the cigar local match filter: configuration registers,
// front end, queue and back end; uses cmf_pkg, cmf_if, cmf_front, cmf_queue and cmf_back
//
//  channel   dir  handshake          word
//  in_word   in   valid/ready        cigar_char, read_start, reference_length, last_char
//  out_word  out  valid/ready        accepted, status, is_local, new_start, new_end,
//                                    extra_mismatches, aligned_size
//  cfg       in   cfg_we (no stall)  cfg_index, cfg_data
//
// one character is taken per cycle unless the queue is full; a non-digit closes a run
// after its last character a result passes the queue, stage 1 and stage 2 registers
// reset clears counters, queue and pipeline valids; registers return to defaults
// the two-entry queue lets the front keep counting while out_word is stalled;
// in_word.ready drops only when the queue is full
`default_nettype none

module cigar_local_match_filter_top
	import cmf_pkg::*;
#(
	parameter int LEN_BITS = 16,
	parameter int POS_BITS = 31
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	cmf_in_if.sink                   in_word,
	cmf_out_if.source                out_word,
	input  wire logic                cfg_we,
	input  wire logic [IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_data
);

	localparam int QW = 4 * LEN_BITS + $bits(cmf_flags_t) + 2 * POS_BITS;

	logic [CFG_BITS-1:0] min_aligned_q, max_clip_q;
	logic                keep_internal_q;

	logic                push, q_full, q_pop, q_valid;
	logic [LEN_BITS-1:0] f_aligned, f_total, f_left, f_trail;
	logic [LEN_BITS-1:0] b_aligned, b_total, b_left, b_trail;
	cmf_flags_t          f_flags, b_flags;
	logic [POS_BITS-1:0] f_start, f_rl, b_start, b_rl;
	logic [QW-1:0]       push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_aligned_q <= MIN_ALIGNED_RESET;
			max_clip_q <= MAX_CLIP_RESET;
			keep_internal_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_ALIGNED: min_aligned_q <= cfg_data;
				CFG_MAX_CLIP: max_clip_q <= cfg_data;
				CFG_KEEP_INTERNAL: keep_internal_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cmf_front #(.LEN_BITS(LEN_BITS), .POS_BITS(POS_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_word    (in_word),
		.q_full     (q_full),
		.push       (push),
		.aligned    (f_aligned),
		.total      (f_total),
		.left_clip  (f_left),
		.trail_clip (f_trail),
		.flags      (f_flags),
		.start      (f_start),
		.ref_len    (f_rl)
	);

	assign push_data = {f_aligned, f_total, f_left, f_trail, f_flags, f_start, f_rl};

	cmf_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.not_empty (q_valid)
	);

	assign {b_aligned, b_total, b_left, b_trail, b_flags, b_start, b_rl} = pop_data;

	cmf_back #(.LEN_BITS(LEN_BITS), .POS_BITS(POS_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.aligned       (b_aligned),
		.total         (b_total),
		.left_clip     (b_left),
		.trail_clip    (b_trail),
		.flags         (b_flags),
		.start         (b_start),
		.ref_len       (b_rl),
		.min_aligned   (min_aligned_q),
		.max_clip      (max_clip_q),
		.keep_internal (keep_internal_q),
		.out_word      (out_word)
	);

endmodule

`default_nettype wire

[rtl/cmf_checker.sv]
// port-level checks on the result channel of the cigar local match filter
// uses cmf_pkg; bound to cigar_local_match_filter_top below
`default_nettype none

module cmf_checker
	import cmf_pkg::*;
#(
	parameter int LEN_BITS = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   accepted,
	input wire logic [STATUS_BITS-1:0] status,
	input wire logic                   is_local,
	input wire logic [LEN_BITS:0]      extra_mismatches
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_OK || status == STATUS_ALL_CLIP ||
			status == STATUS_OVERFLOW))
		else $error("undefined status code");

	a_all_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_ALL_CLIP |-> !accepted && is_local &&
			extra_mismatches == '0)
		else $error("all-clip word not rejected as local");

	a_full_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_local |-> accepted && extra_mismatches == '0)
		else $error("full match not accepted cleanly");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(status) &&
			$stable(is_local) && $stable(extra_mismatches))
		else $error("stalled result word changed");

endmodule

bind cigar_local_match_filter_top cmf_checker #(.LEN_BITS(LEN_BITS)) u_cmf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_word.valid),
	.out_ready        (out_word.ready),
	.accepted         (out_word.accepted),
	.status           (out_word.status),
	.is_local         (out_word.is_local),
	.extra_mismatches (out_word.extra_mismatches)
);

`default_nettype wire
